[src/ssad_pkg.sv]
// ----------------------------------------------------------------------------
// Slot select address decoder package
// Shared types, codes and helpers for the slot select address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssad_pkg;

	localparam logic [2:0] MODE_READ       = 3'd0;
	localparam logic [2:0] MODE_WRITE      = 3'd1;
	localparam logic [2:0] MODE_BANK_SEL   = 3'd2;
	localparam logic [2:0] MODE_MAP_PAGE   = 3'd3;
	localparam logic [2:0] MODE_REG_RANGE  = 3'd4;
	localparam logic [2:0] MODE_UNREG      = 3'd5;

	localparam logic [2:0] ROUTE_SSR  = 3'd0;
	localparam logic [2:0] ROUTE_MEM  = 3'd1;
	localparam logic [2:0] ROUTE_DEV  = 3'd2;
	localparam logic [2:0] ROUTE_HOOK = 3'd3;
	localparam logic [2:0] ROUTE_NONE = 3'd4;

	localparam logic CFG_EXPANDED  = 1'b0;
	localparam logic CFG_ZERO_HOOK = 1'b1;

	localparam int TBL_DEPTH = 128;

	typedef struct packed {
		logic [3:0] count;
		logic [2:0] start;
		logic       dev_wr;
		logic       dev;
		logic       wr;
		logic       rd;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{count: 4'd0, start: 3'd0, dev_wr: 1'b0,
		dev: 1'b0, wr: 1'b1, rd: 1'b0};

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_input;
		logic rd_loop;
		logic emit_access;
		logic tbl_step;
		logic advance;
		logic emit_none;
	} cmd_t;

	typedef struct packed {
		logic in_mem;
		logic is_access;
		logic loop_more;
		logic out_free;
	} status_t;

	function automatic logic [6:0] tbl_index(logic [1:0] ps, logic [1:0] ss, logic [2:0] pg);
		return {ps, ss, pg};
	endfunction

	function automatic logic [1:0] sub_field(logic [7:0] v, logic [1:0] b);
		logic [1:0] r;
		unique case (b)
			2'd0: r = v[1:0];
			2'd1: r = v[3:2];
			2'd2: r = v[5:4];
			default: r = v[7:6];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[src/ssad_ctrl.sv]
// ----------------------------------------------------------------------------
// Slot select address decoder controller
// Sequences acceptance, table lookups, table range walks and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ssad_ctrl
	import ssad_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load     = 1'b1;
					cmd.rd_input = 1'b1;
					state_d      = status.in_mem ? S_EVAL : S_DONE;
				end
			end
			S_EVAL: begin
				if (status.is_access) begin
					if (status.out_free) begin
						cmd.emit_access = 1'b1;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.tbl_step = 1'b1;
					if (status.loop_more) begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_READ: begin
				cmd.rd_loop = 1'b1;
				state_d     = S_EVAL;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.emit_none = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[src/ssad_datapath.sv]
// ----------------------------------------------------------------------------
// Slot select address decoder datapath
// Holds slot state, the page table memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssad_datapath
	import ssad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic [2:0]  mode,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_value,
	input  wire logic [1:0]  bank,
	input  wire logic [1:0]  primary_slot,
	input  wire logic [1:0]  secondary_slot,
	input  wire logic [2:0]  page,
	input  wire logic        read_enable,
	input  wire logic        write_enable,
	input  wire logic [3:0]  page_count,
	input  wire logic        device_writable,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [2:0]       route,
	output logic [7:0]       read_data,
	output logic [1:0]       slot_out,
	output logic [1:0]       subslot_out,
	output logic [2:0]       page_out,
	output logic [15:0]      local_address
);

	logic [3:0]  expanded_q;
	logic        hook_en_q;
	logic [1:0]  bank_sel_q [4];
	logic [7:0]  ssr_q [4];

	logic [2:0]  mode_q;
	logic [15:0] addr_q;
	logic [7:0]  wval_q;
	logic [1:0]  ps_q;
	logic [1:0]  ss_q;
	logic [2:0]  pg_q;
	logic        rde_q;
	logic        wre_q;
	logic [3:0]  cnt_q;
	logic        dwr_q;
	logic [3:0]  k_q;
	logic [3:0]  n_q;

	entry_t                 mem_q [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]   valid_q;
	entry_t                 rdata_q;
	logic                   rvalid_q;

	logic        out_valid_q;
	logic [2:0]  route_q;
	logic [7:0]  rdata_out_q;
	logic [1:0]  slot_q;
	logic [1:0]  sub_q;
	logic [2:0]  page_q;
	logic [15:0] loc_q;

	logic [1:0]  dsl_in;
	logic [1:0]  dss_in;
	logic [6:0]  idx_in;
	logic [6:0]  idx_loop;
	logic [6:0]  rd_idx;
	logic        mem_rd;
	logic        mem_we;
	entry_t      wdata;

	logic [1:0]  abank;
	logic [1:0]  dsl;
	logic [1:0]  dss;
	logic [1:0]  dss_new;
	logic [1:0]  top;
	logic        ssr_hit;
	logic [7:0]  sub_val;
	entry_t      ent;
	logic [15:0] devloc;
	logic [2:0]  a_route;
	logic [7:0]  a_rdata;
	logic [1:0]  a_sub;
	logic [15:0] a_loc;
	logic        is_access;
	logic [3:0]  n_eff;
	logic [3:0]  limit;
	logic [3:0]  next_k;
	logic [4:0]  pg_next;

	// Index for the lookup issued in the accept cycle.
	always_comb begin
		dsl_in = bank_sel_q[address[15:14]];
		dss_in = expanded_q[dsl_in] ? sub_field(ssr_q[dsl_in], address[15:14]) : 2'd0;
		if (mode == MODE_READ || mode == MODE_WRITE) begin
			idx_in = tbl_index(dsl_in, dss_in, address[15:13]);
		end else begin
			idx_in = tbl_index(primary_slot, secondary_slot, page);
		end
	end

	assign idx_loop = tbl_index(ps_q, ss_q, pg_q + k_q[2:0]);
	assign rd_idx   = cmd.rd_input ? idx_in : idx_loop;
	assign mem_rd   = cmd.rd_input || cmd.rd_loop;

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			rdata_q <= mem_q[rd_idx];
		end
		if (mem_we) begin
			mem_q[idx_loop] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (mem_rd) begin
				rvalid_q <= valid_q[rd_idx];
			end
			if (mem_we) begin
				valid_q[idx_loop] <= 1'b1;
			end
		end
	end

	assign ent = rvalid_q ? rdata_q : ENTRY_RESET;

	// Access decode from the latched address.
	always_comb begin
		abank   = addr_q[15:14];
		dsl     = bank_sel_q[abank];
		dss     = expanded_q[dsl] ? sub_field(ssr_q[dsl], abank) : 2'd0;
		top     = bank_sel_q[3];
		ssr_hit = (addr_q == 16'hFFFF) && expanded_q[top];
		sub_val = (dsl == top) ? wval_q : ssr_q[dsl];
		dss_new = expanded_q[dsl] ? sub_field(sub_val, abank) : 2'd0;
		devloc  = addr_q - {ent.start, 13'd0};
		a_rdata = 8'hFF;
		a_sub   = dss;
		a_loc   = 16'd0;
		a_route = ROUTE_NONE;
		if (mode_q == MODE_READ) begin
			priority if (ssr_hit) begin
				a_route = ROUTE_SSR;
				a_rdata = ~ssr_q[top];
			end else if (ent.rd) begin
				a_route = ROUTE_MEM;
				a_loc   = {3'd0, addr_q[12:0]};
			end else if (ent.dev) begin
				a_route = ROUTE_DEV;
				a_loc   = devloc;
			end else begin
				a_route = ROUTE_NONE;
			end
		end else begin
			priority if (ssr_hit) begin
				a_route = ROUTE_SSR;
				a_sub   = dss_new;
			end else if (addr_q == 16'd0 && hook_en_q) begin
				a_route = ROUTE_HOOK;
			end else if (ent.wr) begin
				a_route = ROUTE_MEM;
				a_loc   = {3'd0, addr_q[12:0]};
			end else if (ent.dev && ent.dev_wr) begin
				a_route = ROUTE_DEV;
				a_loc   = devloc;
			end else begin
				a_route = ROUTE_NONE;
			end
		end
	end

	// Table update for map, register and unregister operations.
	always_comb begin
		is_access = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
		n_eff     = (k_q == 4'd0) ? ent.count : n_q;
		limit     = (mode_q == MODE_REG_RANGE) ? cnt_q : n_eff;
		next_k    = k_q + 4'd1;
		pg_next   = {2'd0, pg_q} + {1'b0, next_k};
		wdata     = ent;
		mem_we    = 1'b0;
		unique case (mode_q)
			MODE_MAP_PAGE: begin
				wdata.rd = rde_q;
				wdata.wr = wre_q;
				mem_we   = cmd.tbl_step;
			end
			MODE_REG_RANGE: begin
				if (k_q == 4'd0) begin
					wdata.count = cnt_q;
				end
				if (k_q < cnt_q) begin
					wdata.dev    = 1'b1;
					wdata.dev_wr = dwr_q;
					wdata.start  = pg_q;
				end
				mem_we = cmd.tbl_step;
			end
			MODE_UNREG: begin
				wdata  = ENTRY_RESET;
				mem_we = cmd.tbl_step && (k_q < n_eff);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		status.in_mem    = (mode == MODE_READ) || (mode == MODE_WRITE) ||
			(mode == MODE_MAP_PAGE) || (mode == MODE_REG_RANGE) || (mode == MODE_UNREG);
		status.is_access = is_access;
		status.loop_more = ((mode_q == MODE_REG_RANGE) || (mode_q == MODE_UNREG)) &&
			(next_k < limit) && (pg_next < 5'd8);
		status.out_free  = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			addr_q <= address;
			wval_q <= write_value;
			ps_q   <= primary_slot;
			ss_q   <= secondary_slot;
			pg_q   <= page;
			rde_q  <= read_enable;
			wre_q  <= write_enable;
			cnt_q  <= page_count;
			dwr_q  <= device_writable;
		end
		if (cmd.tbl_step && k_q == 4'd0) begin
			n_q <= ent.count;
		end
		if (cmd.emit_access) begin
			route_q     <= a_route;
			rdata_out_q <= a_rdata;
			slot_q      <= dsl;
			sub_q       <= a_sub;
			page_q      <= addr_q[15:13];
			loc_q       <= a_loc;
		end else if (cmd.emit_none) begin
			route_q     <= ROUTE_NONE;
			rdata_out_q <= 8'hFF;
			slot_q      <= 2'd0;
			sub_q       <= 2'd0;
			page_q      <= 3'd0;
			loc_q       <= 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expanded_q  <= '0;
			hook_en_q   <= 1'b0;
			bank_sel_q  <= '{default: 2'd0};
			ssr_q       <= '{default: 8'd0};
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_EXPANDED:  expanded_q <= cfg_data;
					CFG_ZERO_HOOK: hook_en_q  <= cfg_data[0];
					default:       hook_en_q  <= hook_en_q;
				endcase
			end
			if (cmd.load && mode == MODE_BANK_SEL) begin
				bank_sel_q[bank] <= primary_slot;
			end
			if (cmd.emit_access && mode_q == MODE_WRITE && ssr_hit) begin
				ssr_q[top] <= wval_q;
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.advance) begin
				k_q <= next_k;
			end
			if (cmd.emit_access || cmd.emit_none) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid      = out_valid_q;
	assign route         = route_q;
	assign read_data     = rdata_out_q;
	assign slot_out      = slot_q;
	assign subslot_out   = sub_q;
	assign page_out      = page_q;
	assign local_address = loc_q;

endmodule

`default_nettype wire

[src/slot_select_address_decoder.sv]
// Reads and writes do a registered read of the page table memory on acceptance, then
// register the result once the output is free; only then is a new request accepted.
// Bank select and unused modes return route none; map page writes its entry first.
// Range register and unregister walk N pages (1 to 8), a table read and write per page.
// Reset: all banks select slot 0, subslot registers and config clear, and the
// whole page table reads at once as the reset entry (writable) through valid bits.
// ----------------------------------------------------------------------------
// Slot select address decoder
// Decodes CPU accesses to slot, subslot, page and route, and keeps the page table.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_select_address_decoder
	import ssad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// address[15:0], write_value[23:16], bank[25:24], primary_slot[27:26],
	// secondary_slot[29:28], page[32:30], read_enable[33], write_enable[34],
	// page_count[38:35], device_writable[39]
	input  wire logic [39:0] s_tdata,
	// mode[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0], slot_out[9:8], subslot_out[11:10], page_out[14:12],
	// local_address[30:15], zero[31]
	output logic [31:0]      m_tdata,
	// route[2:0]
	output logic [2:0]       m_tuser
);

	cmd_t        cmd;
	status_t     status;
	logic [7:0]  read_data;
	logic [1:0]  slot_out;
	logic [1:0]  subslot_out;
	logic [2:0]  page_out;
	logic [15:0] local_address;

	ssad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ssad_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (s_tuser),
		.address         (s_tdata[15:0]),
		.write_value     (s_tdata[23:16]),
		.bank            (s_tdata[25:24]),
		.primary_slot    (s_tdata[27:26]),
		.secondary_slot  (s_tdata[29:28]),
		.page            (s_tdata[32:30]),
		.read_enable     (s_tdata[33]),
		.write_enable    (s_tdata[34]),
		.page_count      (s_tdata[38:35]),
		.device_writable (s_tdata[39]),
		.cmd             (cmd),
		.status          (status),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.route           (m_tuser),
		.read_data       (read_data),
		.slot_out        (slot_out),
		.subslot_out     (subslot_out),
		.page_out        (page_out),
		.local_address   (local_address)
	);

	assign m_tdata = {1'b0, local_address, page_out, subslot_out, slot_out, read_data};

endmodule

`default_nettype wire
